// ===== hdl/tssc_pkg.sv =====
// Shared constants, codes and types of the TeX syntax style classifier.
package tssc_pkg;

    localparam int CP_W       = 21;
    localparam int STYLE_W    = 3;
    localparam int MAX_EMIT   = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int DEPTH_W    = 8;
    localparam logic [DEPTH_W-1:0] MAX_NEST = 8'd255;

    localparam logic [STYLE_W-1:0] ST_DEFAULT = 3'd0;
    localparam logic [STYLE_W-1:0] ST_COMMENT = 3'd1;
    localparam logic [STYLE_W-1:0] ST_STRING  = 3'd2;
    localparam logic [STYLE_W-1:0] ST_COMMAND = 3'd3;
    localparam logic [STYLE_W-1:0] ST_KEYWORD = 3'd4;
    localparam logic [STYLE_W-1:0] ST_ARG     = 3'd5;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_COMMENT   = 4'd1;
    localparam logic [3:0] PH_STR       = 4'd2;
    localparam logic [3:0] PH_STR_QUOTE = 4'd3;
    localparam logic [3:0] PH_CMD_START = 4'd4;
    localparam logic [3:0] PH_CMD_NAME  = 4'd5;
    localparam logic [3:0] PH_CMD_GAP   = 4'd6;
    localparam logic [3:0] PH_KEYWORD   = 4'd7;
    localparam logic [3:0] PH_ARG       = 4'd8;

    localparam logic [1:0] HK_NONE     = 2'd0;
    localparam logic [1:0] HK_BACKTICK = 2'd1;
    localparam logic [1:0] HK_AT       = 2'd2;
    localparam logic [1:0] HK_AT_C     = 2'd3;

    localparam logic [CP_W-1:0] CH_NUL       = 21'h00;
    localparam logic [CP_W-1:0] CH_TAB       = 21'h09;
    localparam logic [CP_W-1:0] CH_NL        = 21'h0A;
    localparam logic [CP_W-1:0] CH_SPACE     = 21'h20;
    localparam logic [CP_W-1:0] CH_DQUOTE    = 21'h22;
    localparam logic [CP_W-1:0] CH_PERCENT   = 21'h25;
    localparam logic [CP_W-1:0] CH_QUOTE     = 21'h27;
    localparam logic [CP_W-1:0] CH_AT        = 21'h40;
    localparam logic [CP_W-1:0] CH_LBRACKET  = 21'h5B;
    localparam logic [CP_W-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CH_RBRACKET  = 21'h5D;
    localparam logic [CP_W-1:0] CH_BACKTICK  = 21'h60;
    localparam logic [CP_W-1:0] CH_LOWER_C   = 21'h63;
    localparam logic [CP_W-1:0] CH_LBRACE    = 21'h7B;
    localparam logic [CP_W-1:0] CH_RBRACE    = 21'h7D;
    localparam logic [CP_W-1:0] CH_TILDE     = 21'h7E;

    typedef struct packed {
        logic [1:0]                       count;
        logic [MAX_EMIT-1:0][STYLE_W-1:0] style;
        logic                             last;
    } t_step_res;

endpackage

// ===== hdl/tex_syntax_style_classifier_unit.sv =====
// Top level of the TeX / Texinfo syntax style classifier.
// One character is taken per cycle; the parser state updates in the same
// cycle and the zero to three styles it releases go into an eight-entry
// result buffer that drains one style per cycle on the master side. A
// character is accepted while the buffer holds at most five styles, so the
// block sustains one character per cycle as long as the sink takes one
// style per cycle. Styles of a line come out in character order; a held
// backtick or at-sign delays its style by one or two characters, and the
// line's last style carries tlast.
module tex_syntax_style_classifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // markup mode: 0 LaTeX, 1 Texinfo
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] style, [7:3] zero
    output logic        m_axis_tlast    // last_of_line
);
    import tssc_pkg::*;

    logic                 r_texinfo;
    logic [STYLE_W:0]     r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 take, pop;
    t_step_res            res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_texinfo <= 1'b0;
        end else if (i_cfg_valid) begin
            r_texinfo <= i_cfg_data;
        end
    end

    assign s_axis_tready = (r_count <= CNT_W'(FIFO_DEPTH - MAX_EMIT));
    assign take          = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    tssc_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_code    (s_axis_tdata[CP_W-1:0]),
        .i_end     (s_axis_tlast),
        .i_texinfo (r_texinfo),
        .o_res     (res)
    );

    always_comb begin
        n_count = r_count;
        if (take) begin
            n_count = n_count + CNT_W'(res.count);
        end
        if (pop) begin
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int k = 0; k < MAX_EMIT; k++) begin
                if (k < int'(res.count)) begin
                    r_fifo[r_wr_ptr + PTR_W'(k)] <=
                        {res.last && (k == int'(res.count) - 1), res.style[k]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (take) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(res.count);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {5'd0, r_fifo[r_rd_ptr][STYLE_W-1:0]};
    assign m_axis_tlast  = r_fifo[r_rd_ptr][STYLE_W];

endmodule

// ===== hdl/tssc_step.sv =====
// Per-character parser: line state and the styles released by one character.
module tssc_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [tssc_pkg::CP_W-1:0]    i_code,
    input  logic                         i_end,
    input  logic                         i_texinfo,
    output tssc_pkg::t_step_res          o_res
);
    import tssc_pkg::*;

    logic [3:0]         r_phase, n_phase;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [1:0]         r_held, n_held;
    logic               r_stopped, n_stopped;

    logic [MAX_EMIT-1:0][STYLE_W-1:0] emv;
    logic [1:0]                       cnt;

    function automatic logic is_word(input logic [CP_W-1:0] c);
        return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
               (c >= 21'h30 && c <= 21'h39) || c == 21'h5F;
    endfunction

    always_comb begin
        logic done;
        logic [CP_W-1:0] c;
        logic [2:0] k;
        logic [3*STYLE_W-1:0] seq;
        c         = i_code;
        n_phase   = r_phase;
        n_depth   = r_depth;
        n_held    = r_held;
        n_stopped = r_stopped;
        done      = 1'b0;
        k         = 3'd0;
        seq       = '0;

        if (r_stopped) begin
            seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
            done = 1'b1;
        end else begin
            case (r_held)
                HK_BACKTICK: begin
                    n_held = HK_NONE;
                    if (c == CH_BACKTICK) begin
                        seq[k*STYLE_W +: STYLE_W] = ST_STRING; k = k + 3'd1;
                        seq[k*STYLE_W +: STYLE_W] = ST_STRING; k = k + 3'd1;
                        n_phase = PH_STR;
                        done = 1'b1;
                    end else begin
                        seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                    end
                end
                HK_AT: begin
                    if (c == CH_LOWER_C) begin
                        n_held = HK_AT_C;
                        done = 1'b1;
                    end else begin
                        n_held = HK_NONE;
                        seq[k*STYLE_W +: STYLE_W] = ST_COMMAND; k = k + 3'd1;
                        n_phase = PH_CMD_START;
                    end
                end
                HK_AT_C: begin
                    n_held = HK_NONE;
                    if (!is_word(c)) begin
                        seq[k*STYLE_W +: STYLE_W] = ST_COMMENT; k = k + 3'd1;
                        seq[k*STYLE_W +: STYLE_W] = ST_COMMENT; k = k + 3'd1;
                        seq[k*STYLE_W +: STYLE_W] = ST_COMMENT; k = k + 3'd1;
                        n_phase = PH_COMMENT;
                        done = 1'b1;
                    end else begin
                        seq[k*STYLE_W +: STYLE_W] = ST_COMMAND; k = k + 3'd1;
                        seq[k*STYLE_W +: STYLE_W] = ST_COMMAND; k = k + 3'd1;
                        n_phase = PH_CMD_NAME;
                    end
                end
                default: ;
            endcase
        end

        if (!done && n_phase == PH_COMMENT) begin
            seq[k*STYLE_W +: STYLE_W] = ST_COMMENT; k = k + 3'd1;
            done = 1'b1;
        end
        if (!done && (n_phase == PH_STR || n_phase == PH_STR_QUOTE)) begin
            if (c == CH_NUL) begin
                n_stopped = 1'b1;
                seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
            end else if (c == CH_QUOTE) begin
                seq[k*STYLE_W +: STYLE_W] = ST_STRING; k = k + 3'd1;
                n_phase = (n_phase == PH_STR) ? PH_STR_QUOTE : PH_IDLE;
            end else begin
                seq[k*STYLE_W +: STYLE_W] = ST_STRING; k = k + 3'd1;
                n_phase = PH_STR;
            end
            done = 1'b1;
        end
        if (!done && n_phase == PH_CMD_START) begin
            if (c inside {CH_QUOTE, CH_DQUOTE, CH_TILDE, CH_PERCENT, CH_BACKSLASH}) begin
                seq[k*STYLE_W +: STYLE_W] = ST_COMMAND; k = k + 3'd1;
                n_phase = PH_CMD_GAP;
                done = 1'b1;
            end else begin
                n_phase = PH_CMD_NAME;
            end
        end
        if (!done && n_phase == PH_CMD_NAME) begin
            if (c inside {CH_NUL, CH_LBRACE, CH_LBRACKET, CH_SPACE, CH_BACKSLASH}) begin
                n_phase = PH_CMD_GAP;
            end else begin
                seq[k*STYLE_W +: STYLE_W] = ST_COMMAND; k = k + 3'd1;
                done = 1'b1;
            end
        end
        if (!done && n_phase == PH_CMD_GAP) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                done = 1'b1;
            end else if (c == CH_LBRACKET) begin
                seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                n_phase = PH_KEYWORD;
                done = 1'b1;
            end else if (c == CH_LBRACE) begin
                seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                n_depth = '0;
                n_phase = PH_ARG;
                done = 1'b1;
            end else begin
                n_phase = PH_IDLE;
            end
        end
        if (!done && n_phase == PH_KEYWORD) begin
            if (c == CH_NUL) begin
                n_phase = PH_IDLE;
            end else begin
                if (c == CH_RBRACKET) begin
                    seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                    n_phase = PH_CMD_GAP;
                end else begin
                    seq[k*STYLE_W +: STYLE_W] = ST_KEYWORD; k = k + 3'd1;
                end
                done = 1'b1;
            end
        end
        if (!done && n_phase == PH_ARG) begin
            if (c == CH_NUL) begin
                n_phase = PH_IDLE;
            end else begin
                if (c == CH_LBRACE) begin
                    if (n_depth < MAX_NEST) begin
                        n_depth = n_depth + 1'b1;
                    end
                    seq[k*STYLE_W +: STYLE_W] = ST_ARG; k = k + 3'd1;
                end else if (c == CH_RBRACE) begin
                    if (n_depth == '0) begin
                        seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                        n_phase = PH_CMD_GAP;
                    end else begin
                        n_depth = n_depth - 1'b1;
                        seq[k*STYLE_W +: STYLE_W] = ST_ARG; k = k + 3'd1;
                    end
                end else begin
                    seq[k*STYLE_W +: STYLE_W] = ST_ARG; k = k + 3'd1;
                end
                done = 1'b1;
            end
        end
        if (!done) begin
            n_phase = PH_IDLE;
            if (c == CH_NUL || c == CH_NL) begin
                n_stopped = 1'b1;
                seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
            end else if (c == CH_BACKTICK) begin
                n_held = HK_BACKTICK;
            end else if (c == CH_AT) begin
                if (i_texinfo) begin
                    n_held = HK_AT;
                end else begin
                    seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                end
            end else if (c == CH_BACKSLASH) begin
                seq[k*STYLE_W +: STYLE_W] = ST_COMMAND; k = k + 3'd1;
                n_phase = PH_CMD_START;
            end else if (c == CH_PERCENT) begin
                if (i_texinfo) begin
                    seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                end else begin
                    seq[k*STYLE_W +: STYLE_W] = ST_COMMENT; k = k + 3'd1;
                    n_phase = PH_COMMENT;
                end
            end else begin
                seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
            end
        end

        if (i_end) begin
            case (n_held)
                HK_BACKTICK: begin
                    seq[k*STYLE_W +: STYLE_W] = ST_DEFAULT; k = k + 3'd1;
                end
                HK_AT: begin
                    seq[k*STYLE_W +: STYLE_W] = ST_COMMAND; k = k + 3'd1;
                end
                HK_AT_C: begin
                    seq[k*STYLE_W +: STYLE_W] = ST_COMMENT; k = k + 3'd1;
                    seq[k*STYLE_W +: STYLE_W] = ST_COMMENT; k = k + 3'd1;
                end
                default: ;
            endcase
            n_phase   = PH_IDLE;
            n_depth   = '0;
            n_held    = HK_NONE;
            n_stopped = 1'b0;
        end

        emv = seq;
        cnt = (k > 3'd3) ? 2'd3 : k[1:0];
    end

    assign o_res.count = cnt;
    assign o_res.style = emv;
    assign o_res.last  = i_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_depth   <= '0;
            r_held    <= HK_NONE;
            r_stopped <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_depth   <= n_depth;
            r_held    <= n_held;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ===== tb/tex_syntax_style_classifier_unit_tb.sv =====
// Self-checking testbench for the TeX / Texinfo line style classifier.
module tex_syntax_style_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tssc_pkg::*;

    localparam logic MODE_LATEX   = 1'b0;
    localparam logic MODE_TEXINFO = 1'b1;

    localparam logic [CP_W-1:0] MAX_CP = 21'h10FFFF;
    localparam int RANDOM_ITEMS   = 310;
    localparam int ITEMS_PER_MODE = 80;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 120;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int N_ROWS         = 29;

    typedef struct packed {
        logic [STYLE_W-1:0] style;
        logic               last;
    } t_style_beat;

    typedef struct packed {
        logic               mode;
        logic [CP_W-1:0]    cp;
        logic               eol;
        logic               known;
        logic [STYLE_W-1:0] style;
    } t_char_row;

    localparam t_char_row DIR_ROWS [N_ROWS] = '{
        '{MODE_LATEX,   "x",          1'b0, 1'b1, ST_DEFAULT},
        '{MODE_LATEX,   CH_PERCENT,   1'b0, 1'b1, ST_COMMENT},
        '{MODE_LATEX,   CH_NUL,       1'b1, 1'b1, ST_COMMENT},
        '{MODE_LATEX,   CH_BACKSLASH, 1'b0, 1'b1, ST_COMMAND},
        '{MODE_LATEX,   "b",          1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_LBRACKET,  1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   "k",          1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_RBRACKET,  1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_LBRACE,    1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_LBRACE,    1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_RBRACE,    1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_RBRACE,    1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_BACKTICK,  1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_BACKTICK,  1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_QUOTE,     1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_QUOTE,     1'b0, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_BACKTICK,  1'b1, 1'b0, ST_DEFAULT},
        '{MODE_LATEX,   CH_NL,        1'b0, 1'b1, ST_DEFAULT},
        '{MODE_LATEX,   MAX_CP,       1'b1, 1'b1, ST_DEFAULT},
        '{MODE_TEXINFO, CH_PERCENT,   1'b1, 1'b1, ST_DEFAULT},
        '{MODE_TEXINFO, CH_AT,        1'b0, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, CH_LOWER_C,   1'b0, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, CH_SPACE,     1'b1, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, CH_AT,        1'b0, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, CH_LOWER_C,   1'b1, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, CH_AT,        1'b0, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, CH_LOWER_C,   1'b0, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, "x",          1'b1, 1'b0, ST_DEFAULT},
        '{MODE_TEXINFO, CH_AT,        1'b1, 1'b1, ST_COMMAND}
    };

    localparam logic [CP_W-1:0] SPECIALS [16] = '{
        CH_NUL, CH_TAB, CH_NL, CH_SPACE, CH_DQUOTE, CH_PERCENT, CH_QUOTE, CH_AT,
        CH_LBRACKET, CH_BACKSLASH, CH_RBRACKET, CH_BACKTICK, CH_LOWER_C,
        CH_LBRACE, CH_RBRACE, CH_TILDE
    };

    localparam logic [CP_W-1:0] CMD_MARKS [5] = '{
        CH_QUOTE, CH_DQUOTE, CH_TILDE, CH_PERCENT, CH_BACKSLASH
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    tex_syntax_style_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    logic               texinfo = MODE_LATEX;
    logic [3:0]         parse_ph;
    logic [DEPTH_W-1:0] nest_depth;
    logic [1:0]         held_tok;
    logic               line_done;

    logic [STYLE_W-1:0] step_styles [$];
    t_style_beat        styles_due [$];
    logic [CP_W-1:0]    line_cps [$];

    int          mismatches = 0;
    int unsigned cycles = 0;
    int          src_span = 0;
    bit          src_lively = 1'b0;
    bit          hold_sink_req = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        else if (r < 95) return $urandom_range(1, 3);
        else return $urandom_range(8, 30);
    endfunction

    function automatic bit is_word(logic [CP_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic void emit_style(logic [STYLE_W-1:0] s);
        if (step_styles.size() < 4) step_styles.push_back(s);
    endfunction

    function automatic void clear_line_state();
        parse_ph   = PH_IDLE;
        nest_depth = '0;
        held_tok   = HK_NONE;
        line_done  = 1'b0;
    endfunction

    task automatic classify_char(input logic [CP_W-1:0] c);
        bit done;
        if (line_done) begin
            emit_style(ST_DEFAULT);
            return;
        end
        if (held_tok == HK_BACKTICK) begin
            held_tok = HK_NONE;
            if (c == CH_BACKTICK) begin
                emit_style(ST_STRING);
                emit_style(ST_STRING);
                parse_ph = PH_STR;
                return;
            end
            emit_style(ST_DEFAULT);
        end else if (held_tok == HK_AT) begin
            if (c == CH_LOWER_C) begin
                held_tok = HK_AT_C;
                return;
            end
            held_tok = HK_NONE;
            emit_style(ST_COMMAND);
            parse_ph = PH_CMD_START;
        end else if (held_tok == HK_AT_C) begin
            held_tok = HK_NONE;
            if (!is_word(c)) begin
                emit_style(ST_COMMENT);
                emit_style(ST_COMMENT);
                emit_style(ST_COMMENT);
                parse_ph = PH_COMMENT;
                return;
            end
            emit_style(ST_COMMAND);
            emit_style(ST_COMMAND);
            parse_ph = PH_CMD_NAME;
        end
        done = 1'b0;
        while (!done) begin
            done = 1'b1;
            case (parse_ph)
                PH_COMMENT: emit_style(ST_COMMENT);
                PH_STR, PH_STR_QUOTE: begin
                    if (c == CH_NUL) begin
                        line_done = 1'b1;
                        emit_style(ST_DEFAULT);
                    end else if (c == CH_QUOTE) begin
                        emit_style(ST_STRING);
                        parse_ph = (parse_ph == PH_STR) ? PH_STR_QUOTE : PH_IDLE;
                    end else begin
                        emit_style(ST_STRING);
                        parse_ph = PH_STR;
                    end
                end
                PH_CMD_START: begin
                    if (c == CH_QUOTE || c == CH_DQUOTE || c == CH_TILDE ||
                        c == CH_PERCENT || c == CH_BACKSLASH) begin
                        emit_style(ST_COMMAND);
                        parse_ph = PH_CMD_GAP;
                    end else begin
                        parse_ph = PH_CMD_NAME;
                        done = 1'b0;
                    end
                end
                PH_CMD_NAME: begin
                    if (c == CH_NUL || c == CH_LBRACE || c == CH_LBRACKET ||
                        c == CH_SPACE || c == CH_BACKSLASH) begin
                        parse_ph = PH_CMD_GAP;
                        done = 1'b0;
                    end else begin
                        emit_style(ST_COMMAND);
                    end
                end
                PH_CMD_GAP: begin
                    if (c == CH_SPACE || c == CH_TAB) begin
                        emit_style(ST_DEFAULT);
                    end else if (c == CH_LBRACKET) begin
                        emit_style(ST_DEFAULT);
                        parse_ph = PH_KEYWORD;
                    end else if (c == CH_LBRACE) begin
                        emit_style(ST_DEFAULT);
                        nest_depth = '0;
                        parse_ph = PH_ARG;
                    end else begin
                        parse_ph = PH_IDLE;
                        done = 1'b0;
                    end
                end
                PH_KEYWORD: begin
                    if (c == CH_NUL) begin
                        parse_ph = PH_IDLE;
                        done = 1'b0;
                    end else if (c == CH_RBRACKET) begin
                        emit_style(ST_DEFAULT);
                        parse_ph = PH_CMD_GAP;
                    end else begin
                        emit_style(ST_KEYWORD);
                    end
                end
                PH_ARG: begin
                    if (c == CH_NUL) begin
                        parse_ph = PH_IDLE;
                        done = 1'b0;
                    end else if (c == CH_LBRACE) begin
                        if (nest_depth < MAX_NEST) nest_depth++;
                        emit_style(ST_ARG);
                    end else if (c == CH_RBRACE) begin
                        if (nest_depth == 0) begin
                            emit_style(ST_DEFAULT);
                            parse_ph = PH_CMD_GAP;
                        end else begin
                            nest_depth--;
                            emit_style(ST_ARG);
                        end
                    end else begin
                        emit_style(ST_ARG);
                    end
                end
                default: begin
                    parse_ph = PH_IDLE;
                    if (c == CH_NUL || c == CH_NL) begin
                        line_done = 1'b1;
                        emit_style(ST_DEFAULT);
                    end else if (c == CH_BACKTICK) begin
                        held_tok = HK_BACKTICK;
                    end else if (c == CH_AT) begin
                        if (texinfo == MODE_TEXINFO) held_tok = HK_AT;
                        else emit_style(ST_DEFAULT);
                    end else if (c == CH_BACKSLASH) begin
                        emit_style(ST_COMMAND);
                        parse_ph = PH_CMD_START;
                    end else if (c == CH_PERCENT) begin
                        if (texinfo == MODE_TEXINFO) begin
                            emit_style(ST_DEFAULT);
                        end else begin
                            emit_style(ST_COMMENT);
                            parse_ph = PH_COMMENT;
                        end
                    end else begin
                        emit_style(ST_DEFAULT);
                    end
                end
            endcase
        end
    endtask

    task automatic predict_styles(input logic [CP_W-1:0] c, input logic eol);
        step_styles.delete();
        classify_char(c);
        if (eol) begin
            case (held_tok)
                HK_BACKTICK: emit_style(ST_DEFAULT);
                HK_AT:       emit_style(ST_COMMAND);
                HK_AT_C: begin
                    emit_style(ST_COMMENT);
                    emit_style(ST_COMMENT);
                end
                default: ;
            endcase
            clear_line_state();
        end
        while (step_styles.size() > MAX_EMIT) void'(step_styles.pop_back());
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    endtask

    task automatic put_char(input logic [CP_W-1:0] cp, input logic eol, input logic known,
                            input logic [STYLE_W-1:0] typed);
        int gap;
        t_style_beat beat;
        if (src_span == 0) begin
            src_span   = $urandom_range(10, 60);
            src_lively = ($urandom_range(0, 2) != 0);
        end
        src_span--;
        gap = src_lively ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cp};
        s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_styles(cp, eol);
        if (known) begin
            beat.style = typed;
            beat.last  = eol;
            styles_due.push_back(beat);
        end else begin
            for (int k = 0; k < step_styles.size(); k++) begin
                beat.style = step_styles[k];
                beat.last  = eol && (k == step_styles.size() - 1);
                styles_due.push_back(beat);
            end
        end
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_cps.size(); i++)
            put_char(line_cps[i], i == line_cps.size() - 1, 1'b0, ST_DEFAULT);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (styles_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic mode_bit);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode_bit;
        do @(posedge i_clk); while (!o_cfg_ready);
        texinfo = mode_bit;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CP_W-1:0] word_char();
        case ($urandom_range(0, 5))
            0: return CP_W'("0" + $urandom_range(0, 9));
            1: return "_";
            2: return CP_W'("A" + $urandom_range(0, 25));
            default: return CP_W'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [CP_W-1:0] body_char();
        if ($urandom_range(0, 3) == 0) return SPECIALS[$urandom_range(0, 15)];
        return $urandom_range(0, 1) ? word_char() : CP_W'($urandom_range(32, 126));
    endfunction

    task automatic add_command(input logic [CP_W-1:0] lead);
        int open;
        line_cps.push_back(lead);
        if ($urandom_range(0, 3) == 0) line_cps.push_back(CMD_MARKS[$urandom_range(0, 4)]);
        else repeat ($urandom_range(1, 5)) line_cps.push_back(word_char());
        repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(0, 1))
                line_cps.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            if ($urandom_range(0, 2) == 0) begin
                line_cps.push_back(CH_LBRACKET);
                repeat ($urandom_range(0, 3)) line_cps.push_back(body_char());
                if ($urandom_range(0, 5) != 0) line_cps.push_back(CH_RBRACKET);
            end else begin
                line_cps.push_back(CH_LBRACE);
                open = 0;
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            line_cps.push_back(CH_LBRACE);
                            open++;
                        end
                        1: if (open > 0) begin
                            line_cps.push_back(CH_RBRACE);
                            open--;
                        end
                        default: line_cps.push_back(body_char());
                    endcase
                end
                if ($urandom_range(0, 5) != 0) repeat (open + 1) line_cps.push_back(CH_RBRACE);
            end
        end
    endtask

    task automatic compose_line();
        line_cps.delete();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1: repeat ($urandom_range(1, 4))
                    line_cps.push_back(CP_W'($urandom_range(32, 126)));
                2: begin
                    line_cps.push_back(CH_BACKTICK);
                    line_cps.push_back(CH_BACKTICK);
                    repeat ($urandom_range(0, 4)) line_cps.push_back(body_char());
                    case ($urandom_range(0, 5))
                        0: ;
                        1: line_cps.push_back(CH_QUOTE);
                        2: line_cps.push_back(CH_NUL);
                        default: begin
                            line_cps.push_back(CH_QUOTE);
                            line_cps.push_back(CH_QUOTE);
                        end
                    endcase
                end
                3, 4: add_command(CH_BACKSLASH);
                5: add_command(CH_AT);
                6: begin
                    if (texinfo == MODE_TEXINFO) begin
                        line_cps.push_back(CH_AT);
                        line_cps.push_back(CH_LOWER_C);
                        line_cps.push_back($urandom_range(0, 1) ? CH_SPACE
                                                                : SPECIALS[$urandom_range(0, 15)]);
                    end else begin
                        line_cps.push_back(CH_PERCENT);
                    end
                    repeat ($urandom_range(0, 3)) line_cps.push_back(body_char());
                end
                7: line_cps.push_back(CP_W'($urandom_range(0, MAX_CP)));
                8: line_cps.push_back(SPECIALS[$urandom_range(0, 15)]);
                default: begin
                    line_cps.push_back(CH_AT);
                    line_cps.push_back(CH_LOWER_C);
                    if ($urandom_range(0, 1)) line_cps.push_back(word_char());
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : style_check
        t_style_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (styles_due.size() == 0) begin
                note_mismatch("style beat with nothing due", -1, m_axis_tdata[2:0]);
            end else begin
                want = styles_due.pop_front();
                if (m_axis_tdata[2:0] !== want.style)
                    note_mismatch("style", want.style, m_axis_tdata[2:0]);
                if (m_axis_tlast !== want.last)
                    note_mismatch("tlast", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : sink_side
        int stall;
        int span;
        bit choppy;
        stall  = 0;
        span   = 0;
        choppy = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink_req) begin
                hold_sink_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (span == 0) begin
                span   = $urandom_range(20, 80);
                choppy = ($urandom_range(0, 2) != 0);
            end
            span--;
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (choppy) stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        t_char_row row;
        int sent;
        int since_cfg;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = MODE_LATEX;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        clear_line_state();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_mode(MODE_LATEX);

        for (int i = 0; i < N_ROWS; i++) begin
            row = DIR_ROWS[i];
            if (row.mode != texinfo) begin
                settle();
                write_mode(row.mode);
            end
            put_char(row.cp, row.eol, row.known, row.style);
        end

        // saturate the brace counter while the sink holds off
        settle();
        write_mode(MODE_LATEX);
        hold_sink_req = 1'b1;
        line_cps.delete();
        line_cps.push_back(CH_BACKSLASH);
        line_cps.push_back("x");
        line_cps.push_back(CH_LBRACE);
        repeat (260) line_cps.push_back(CH_LBRACE);
        repeat (258) line_cps.push_back(CH_RBRACE);
        line_cps.push_back("z");
        send_line();

        sent      = 0;
        since_cfg = ITEMS_PER_MODE;
        while (sent < RANDOM_ITEMS) begin
            if (since_cfg >= ITEMS_PER_MODE) begin
                settle();
                write_mode(~texinfo);
                since_cfg = 0;
            end
            compose_line();
            send_line();
            sent      += line_cps.size();
            since_cfg += line_cps.size();
        end

        settle();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
